FILE: rtl/tct_pkg.sv
// Shared types and constants for the touch contact tracker.
// Depends on nothing; the tracker top level, datapath and controller import it.
package tct_pkg;

	localparam int MAX_CONTACTS_DEF = 16;

	localparam logic [2:0] PH_BEGAN      = 3'd0;
	localparam logic [2:0] PH_MOVED      = 3'd1;
	localparam logic [2:0] PH_STATIONARY = 3'd2;
	localparam logic [2:0] PH_ENDED      = 3'd3;
	localparam logic [2:0] PH_CANCELLED  = 3'd4;

	typedef enum logic [1:0] {
		OP_FRAME_START = 2'd0,
		OP_REPORT      = 2'd1,
		OP_READ        = 2'd2,
		OP_FRAME_END   = 2'd3
	} tct_op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] contact_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [9:0]  pressure_in;
	} tct_req_t;

	typedef struct packed {
		logic        entry_valid;
		logic [31:0] entry_id;
		logic [15:0] entry_x;
		logic [15:0] entry_y;
		logic [9:0]  entry_pressure;
		logic [2:0]  entry_phase;
		logic        dropped;
		logic        last;
	} tct_rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] x;
		logic [15:0] y;
		logic [9:0]  pressure;
	} tct_rec_t;

	typedef enum logic [2:0] {
		WR_NONE    = 3'd0,
		WR_MARK    = 3'd1,
		WR_UPDATE  = 3'd2,
		WR_APPEND  = 3'd3,
		WR_COMPACT = 3'd4
	} tct_wr_t;

	typedef enum logic [2:0] {
		OUT_NONE   = 3'd0,
		OUT_UPDATE = 3'd1,
		OUT_APPEND = 3'd2,
		OUT_DROP   = 3'd3,
		OUT_EMPTY  = 3'd4,
		OUT_READ   = 3'd5
	} tct_out_t;

	typedef struct packed {
		logic     in_ready;
		logic     capture;
		logic     ptr_clr;
		logic     idx_inc;
		logic     cnt_inc;
		logic     cnt_load_w;
		tct_wr_t  wr;
		tct_out_t out;
	} tct_cmd_t;

	typedef struct packed {
		tct_op_t op;
		logic    cnt_zero;
		logic    idx_done;
		logic    idx_last;
		logic    full;
		logic    hit;
		logic    out_free;
	} tct_sts_t;

endpackage

FILE: rtl/tct_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
// Payload type is set per instance; used by the tracker top level.
interface tct_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/touch_contact_tracker.sv
// Touch contact tracker top level: channel ports, controller and datapath.
// Depends on tct_pkg, tct_chan_if, tct_controller and tct_datapath.
//
// Usage: req carries one operation per transfer (frame start, contact report,
// read table, frame end); rsp returns result items, each with last set on the
// final result of its operation. Frame start and frame end return nothing.
// req.ready is high only while the block is idle; one operation at a time.
// The table memory read is registered: search, read and frame end visit each
// entry in a read state and act on it in a compare, output or write state.
// A result sits in an output register; while rsp.ready is low the walk holds
// on the pending entry and resumes once the register is taken.
// Reset clears the contact count and the output valid flag; table contents
// need no clearing and are never read before being written.
module touch_contact_tracker import tct_pkg::*; #(
	parameter int MAX_CONTACTS = MAX_CONTACTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tct_chan_if.sink    req,
	tct_chan_if.source  rsp
);

	tct_cmd_t cmd;
	tct_sts_t sts;
	tct_req_t req_payload;
	tct_rsp_t rsp_payload;
	logic     rsp_valid;

	assign req_payload = req.payload;
	assign req.ready   = cmd.in_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = rsp_payload;

	tct_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	tct_datapath #(
		.MAX_CONTACTS (MAX_CONTACTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_payload (req_payload),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp_valid),
		.rsp_payload (rsp_payload)
	);

endmodule

FILE: rtl/tct_datapath.sv
// Contact table storage, walk counters and result register.
// Depends on tct_pkg; driven by tct_controller commands.
module tct_datapath import tct_pkg::*; #(
	parameter int MAX_CONTACTS = MAX_CONTACTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tct_cmd_t cmd,
	output tct_sts_t sts,
	input  tct_req_t req_payload,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	output tct_rsp_t rsp_payload
);

	localparam int CW = $clog2(MAX_CONTACTS + 1);
	localparam int AW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

	tct_req_t   req_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] cnt_q;

	tct_rec_t   rec_mem [MAX_CONTACTS];
	logic [2:0] ph_mem  [MAX_CONTACTS];
	tct_rec_t   rd_rec_q;
	logic [2:0] rd_ph_q;

	logic       out_valid_q;
	tct_rsp_t   out_q;

	logic       moved;
	logic       keep;
	logic       wr_rec_en;
	logic       wr_ph_en;
	logic [AW-1:0] wr_addr;
	tct_rec_t   wr_rec;
	logic [2:0] wr_ph;
	tct_rsp_t   out_d;
	logic [CW:0] idx_next;

	assign moved    = (rd_rec_q.x != req_q.pos_x) || (rd_rec_q.y != req_q.pos_y);
	assign keep     = (rd_ph_q != PH_ENDED) && (rd_ph_q != PH_CANCELLED);
	assign idx_next = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};

	assign sts.op       = tct_op_t'(req_q.operation);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.idx_done = (idx_q == cnt_q);
	assign sts.idx_last = (idx_next == {1'b0, cnt_q});
	assign sts.full     = (cnt_q == CW'(MAX_CONTACTS));
	assign sts.hit      = (rd_rec_q.id == req_q.contact_id);
	assign sts.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_payload;
		end
	end

	always_comb begin
		wr_rec_en = 1'b0;
		wr_ph_en  = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_rec    = rd_rec_q;
		wr_ph     = PH_BEGAN;
		case (cmd.wr)
			WR_MARK: begin
				wr_ph_en = 1'b1;
				wr_ph    = PH_ENDED;
			end
			WR_UPDATE: begin
				wr_rec_en = 1'b1;
				wr_ph_en  = 1'b1;
				if (moved) begin
					wr_rec.x = req_q.pos_x;
					wr_rec.y = req_q.pos_y;
					wr_ph    = PH_MOVED;
				end else begin
					wr_ph = PH_STATIONARY;
				end
			end
			WR_APPEND: begin
				wr_rec_en = 1'b1;
				wr_ph_en  = 1'b1;
				wr_addr   = cnt_q[AW-1:0];
				wr_rec    = '{id: req_q.contact_id, x: req_q.pos_x, y: req_q.pos_y,
					pressure: req_q.pressure_in};
				wr_ph     = PH_BEGAN;
			end
			WR_COMPACT: begin
				// move a surviving entry down to the write pointer
				wr_rec_en = keep;
				wr_ph_en  = keep;
				wr_addr   = w_q[AW-1:0];
				wr_ph     = (rd_ph_q == PH_BEGAN) ? PH_BEGAN : PH_STATIONARY;
			end
			default: begin
				wr_rec_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_rec_en) begin
			rec_mem[wr_addr] <= wr_rec;
		end
		if (wr_ph_en) begin
			ph_mem[wr_addr] <= wr_ph;
		end
		rd_rec_q <= rec_mem[idx_q[AW-1:0]];
		rd_ph_q  <= ph_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			w_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.ptr_clr) begin
				idx_q <= '0;
				w_q   <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_next[CW-1:0];
				end
				if (cmd.wr == WR_COMPACT && keep) begin
					w_q <= w_q + {{(CW-1){1'b0}}, 1'b1};
				end
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + {{(CW-1){1'b0}}, 1'b1};
			end else if (cmd.cnt_load_w) begin
				cnt_q <= w_q;
			end
		end
	end

	always_comb begin
		out_d = '{entry_valid: 1'b1, entry_id: rd_rec_q.id, entry_x: rd_rec_q.x,
			entry_y: rd_rec_q.y, entry_pressure: rd_rec_q.pressure,
			entry_phase: rd_ph_q, dropped: 1'b0, last: 1'b1};
		case (cmd.out)
			OUT_UPDATE: begin
				out_d.entry_x     = wr_rec.x;
				out_d.entry_y     = wr_rec.y;
				out_d.entry_phase = wr_ph;
			end
			OUT_APPEND, OUT_DROP: begin
				out_d.entry_id       = req_q.contact_id;
				out_d.entry_x        = req_q.pos_x;
				out_d.entry_y        = req_q.pos_y;
				out_d.entry_pressure = req_q.pressure_in;
				out_d.entry_phase    = PH_BEGAN;
				out_d.dropped        = (cmd.out == OUT_DROP);
			end
			OUT_EMPTY: begin
				out_d      = '0;
				out_d.last = 1'b1;
			end
			OUT_READ: begin
				out_d.last = sts.idx_last;
			end
			default: begin
				out_d.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out != OUT_NONE) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_payload = out_q;

endmodule

FILE: rtl/tct_controller.sv
// Sequencer for the contact tracker: decodes one operation and walks the table.
// Depends on tct_pkg; commands tct_datapath and reads its status.
module tct_controller import tct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  tct_sts_t sts,
	output tct_cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_DECODE   = 11'b000_0000_0010,
		S_MARK     = 11'b000_0000_0100,
		S_SRCH_RD  = 11'b000_0000_1000,
		S_SRCH_CMP = 11'b000_0001_0000,
		S_APPEND   = 11'b000_0010_0000,
		S_READ_RD  = 11'b000_0100_0000,
		S_READ_OUT = 11'b000_1000_0000,
		S_EMPTY    = 11'b001_0000_0000,
		S_CMP_RD   = 11'b010_0000_0000,
		S_CMP_WR   = 11'b100_0000_0000
	} tct_state_t;

	tct_state_t state_q;
	tct_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '{in_ready: 1'b0, capture: 1'b0, ptr_clr: 1'b0, idx_inc: 1'b0,
			cnt_inc: 1'b0, cnt_load_w: 1'b0, wr: WR_NONE, out: OUT_NONE};
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					cmd.ptr_clr = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_FRAME_START: state_d = S_MARK;
					OP_REPORT:      state_d = sts.cnt_zero ? S_APPEND : S_SRCH_RD;
					OP_READ:        state_d = sts.cnt_zero ? S_EMPTY : S_READ_RD;
					OP_FRAME_END:   state_d = S_CMP_RD;
					default:        state_d = S_IDLE;
				endcase
			end
			S_MARK: begin
				if (sts.idx_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.wr      = WR_MARK;
					cmd.idx_inc = 1'b1;
				end
			end
			S_SRCH_RD: begin
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (sts.hit) begin
					// hold the read address until the result register frees up
					if (sts.out_free) begin
						cmd.wr  = WR_UPDATE;
						cmd.out = OUT_UPDATE;
						state_d = S_IDLE;
					end
				end else if (sts.idx_last) begin
					state_d = S_APPEND;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_APPEND: begin
				if (sts.out_free) begin
					if (sts.full) begin
						cmd.out = OUT_DROP;
					end else begin
						cmd.wr      = WR_APPEND;
						cmd.cnt_inc = 1'b1;
						cmd.out     = OUT_APPEND;
					end
					state_d = S_IDLE;
				end
			end
			S_READ_RD: begin
				state_d = S_READ_OUT;
			end
			S_READ_OUT: begin
				if (sts.out_free) begin
					cmd.out = OUT_READ;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_READ_RD;
					end
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.out = OUT_EMPTY;
					state_d = S_IDLE;
				end
			end
			S_CMP_RD: begin
				if (sts.idx_done) begin
					cmd.cnt_load_w = 1'b1;
					state_d        = S_IDLE;
				end else begin
					state_d = S_CMP_WR;
				end
			end
			S_CMP_WR: begin
				cmd.wr      = WR_COMPACT;
				cmd.idx_inc = 1'b1;
				state_d     = S_CMP_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
